### hw/rtl/bca_pkg.sv
package bca_pkg;

   // Request codes carried in the req_type field.
   localparam logic [2:0] REQ_TICK       = 3'd0;
   localparam logic [2:0] REQ_SET_TIME   = 3'd1;
   localparam logic [2:0] REQ_SET_ALARM  = 3'd2;
   localparam logic [2:0] REQ_SNOOZE     = 3'd3;
   localparam logic [2:0] REQ_SHUTDOWN   = 3'd4;

   // Configuration register indexes.
   localparam logic [0:0] CSR_TICKS_PER_SECOND = 1'b0;
   localparam logic [0:0] CSR_ALARM_ENABLE     = 1'b1;

   // Digit limits for the BCD counters.
   localparam logic [4:0] UNITS_WRAP      = 5'd10;
   localparam logic [2:0] TENS_LIMIT_MS   = 3'd6;
   localparam logic [2:0] TENS_LIMIT_HR   = 3'd3;
   localparam logic [3:0] HOUR_TENS_LAST  = 4'd2;
   localparam logic [3:0] HOUR_UNITS_WRAP = 4'd4;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [23:0] value_bcd;
      logic        args_present;
      logic [7:0]  offset_minutes;
   } req_beat_type;

   typedef struct packed {
      logic [23:0] time_bcd;
      logic [23:0] alarm_bcd;
      logic        alarm_match;
      logic        in_alarm;
      logic        time_valid;
      logic        request_ok;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SNOOZE,
      ST_DONE
   } state_type;

   // Increment one BCD digit pair; the units roll at ten and the tens at the limit.
   function automatic logic [7:0] bump_pair(logic [7:0] pair, logic [2:0] tens_limit);
      logic [4:0] units;
      logic [4:0] tens;
      units = {1'b0, pair[3:0]} + 5'd1;
      tens  = {1'b0, pair[7:4]};
      if (units >= UNITS_WRAP) begin
         units = 5'd0;
         tens  = tens + 5'd1;
         if (tens >= {2'b00, tens_limit}) begin
            tens = 5'd0;
         end
      end
      return {tens[3:0], units[3:0]};
   endfunction

endpackage

### hw/rtl/bca_bump.sv
module bca_bump (
   input  logic [23:0] value_in,
   input  logic        minutes_only,
   output logic [23:0] value_out
);

   logic [7:0] sec_next;
   logic [7:0] min_next;
   logic [7:0] hr_pair;
   logic [7:0] hr_next;
   logic       min_carry;
   logic       hr_carry;

   // Seconds pair; it carries into the minutes when it returns to 00.
   always_comb begin
      sec_next  = bca_pkg::bump_pair(value_in[7:0], bca_pkg::TENS_LIMIT_MS);
      min_carry = minutes_only || (sec_next == 8'h00);
   end

   // Minutes pair, stepped by a seconds carry or directly.
   always_comb begin
      min_next = min_carry ? bca_pkg::bump_pair(value_in[15:8], bca_pkg::TENS_LIMIT_MS)
                           : value_in[15:8];
      hr_carry = min_carry && (min_next == 8'h00);
   end

   // Hours pair, with the wrap from 23 back to 00.
   always_comb begin
      hr_pair = bca_pkg::bump_pair(value_in[23:16], bca_pkg::TENS_LIMIT_HR);
      if ((hr_pair[7:4] == bca_pkg::HOUR_TENS_LAST) &&
          (hr_pair[3:0] >= bca_pkg::HOUR_UNITS_WRAP)) begin
         hr_next = 8'h00;
      end else begin
         hr_next = hr_pair;
      end
   end

   assign value_out = {hr_carry ? hr_next : value_in[23:16],
                       min_next,
                       minutes_only ? value_in[7:0] : sec_next};

endmodule

### hw/rtl/bcd_alarm_clock.sv
// Channel  | Direction | Handshake             | Payload
// req_     | in        | req_valid / req_stall | bca_pkg::req_beat_type
// rsp_     | out       | rsp_valid / rsp_stall | bca_pkg::rsp_beat_type
// csr_     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// A beat goes from accept through an execute state, a state that loads the
// result register and back to idle before the next accept. A snooze adds a
// minute-stepping state, one minute step a cycle through the shared BCD incrementer. The input
// is stalled from accept until the result is loaded into the output register,
// which holds it while rsp_stall is high and so also holds back the next load.
// Reset is synchronous and clears the time, alarm, prescaler and configuration registers.
module bcd_alarm_clock (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bca_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bca_pkg::rsp_beat_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [7:0]            csr_data
);

   bca_pkg::state_type    state_ff, state_in;
   bca_pkg::req_beat_type req_ff, req_in;
   bca_pkg::rsp_beat_type rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            tick_cnt_ff, tick_cnt_in;
   logic [23:0]           clock_ff, clock_in;
   logic [23:0]           alarm_ff, alarm_in;
   logic                  latched_ff, latched_in;
   logic                  valid_ff, valid_in;
   logic                  ok_ff, ok_in;
   logic [7:0]            step_cnt_ff, step_cnt_in;
   logic [7:0]            tps_ff, tps_in;
   logic                  enable_ff, enable_in;

   logic [23:0]           bump_value;
   logic                  bump_minutes_only;
   logic [23:0]           bump_result;
   logic [8:0]            tick_sum;
   logic [8:0]            tick_term;
   logic                  alarm_hit;

   // Shared BCD incrementer for clock seconds and snooze minutes.
   bca_bump u_bump (
      .value_in     (bump_value),
      .minutes_only (bump_minutes_only),
      .value_out    (bump_result)
   );

   assign req_stall = (state_ff != bca_pkg::ST_IDLE);
   assign csr_ready = (state_ff == bca_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Prescaler arithmetic; a terminal count of zero acts as one.
   assign tick_sum  = {1'b0, tick_cnt_ff} + 9'd1;
   assign tick_term = (tps_ff == 8'd0) ? 9'd1 : {1'b0, tps_ff};
   assign alarm_hit = (req_ff.req_type == bca_pkg::REQ_TICK) && enable_ff &&
                      (clock_ff == alarm_ff);

   // Sequencer: next state, datapath updates and result loading.
   always_comb begin
      state_in          = state_ff;
      req_in            = req_ff;
      rsp_data_in       = rsp_data_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      tick_cnt_in       = tick_cnt_ff;
      clock_in          = clock_ff;
      alarm_in          = alarm_ff;
      latched_in        = latched_ff;
      valid_in          = valid_ff;
      ok_in             = ok_ff;
      step_cnt_in       = step_cnt_ff;
      tps_in            = tps_ff;
      enable_in         = enable_ff;
      bump_value        = clock_ff;
      bump_minutes_only = 1'b0;

      unique case (state_ff)
         bca_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = bca_pkg::ST_EXEC;
            end
         end
         bca_pkg::ST_EXEC: begin
            ok_in    = 1'b1;
            state_in = bca_pkg::ST_DONE;
            unique case (req_ff.req_type) inside
               bca_pkg::REQ_TICK: begin
                  if (tick_sum >= tick_term) begin
                     tick_cnt_in = 8'd0;
                     clock_in    = bump_result;
                  end else begin
                     tick_cnt_in = tick_sum[7:0];
                  end
               end
               bca_pkg::REQ_SET_TIME, bca_pkg::REQ_SET_ALARM: begin
                  if (req_ff.args_present) begin
                     if (req_ff.req_type == bca_pkg::REQ_SET_TIME) begin
                        clock_in = req_ff.value_bcd;
                     end else begin
                        alarm_in = req_ff.value_bcd;
                     end
                     valid_in = 1'b1;
                  end else begin
                     valid_in = 1'b0;
                     ok_in    = 1'b0;
                  end
               end
               bca_pkg::REQ_SNOOZE: begin
                  alarm_in    = clock_ff;
                  step_cnt_in = req_ff.offset_minutes;
                  latched_in  = 1'b0;
                  if (req_ff.offset_minutes != 8'd0) begin
                     state_in = bca_pkg::ST_SNOOZE;
                  end
               end
               bca_pkg::REQ_SHUTDOWN: begin
                  latched_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         bca_pkg::ST_SNOOZE: begin
            // One minute step per cycle until the offset is used up.
            bump_value        = alarm_ff;
            bump_minutes_only = 1'b1;
            alarm_in          = bump_result;
            step_cnt_in       = step_cnt_ff - 8'd1;
            if (step_cnt_ff == 8'd1) begin
               state_in = bca_pkg::ST_DONE;
            end
         end
         bca_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.time_bcd    = valid_ff ? clock_ff : 24'd0;
               rsp_data_in.alarm_bcd   = alarm_ff;
               rsp_data_in.alarm_match = alarm_hit;
               rsp_data_in.in_alarm    = latched_ff || alarm_hit;
               rsp_data_in.time_valid  = valid_ff;
               rsp_data_in.request_ok  = ok_ff;
               latched_in              = latched_ff || alarm_hit;
               state_in                = bca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bca_pkg::ST_IDLE;
         end
      endcase

      // Register writes are taken only while idle.
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bca_pkg::CSR_TICKS_PER_SECOND: tps_in    = csr_data;
            bca_pkg::CSR_ALARM_ENABLE:     enable_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bca_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tick_cnt_ff  <= 8'd0;
         clock_ff     <= 24'd0;
         alarm_ff     <= 24'd0;
         latched_ff   <= 1'b0;
         valid_ff     <= 1'b0;
         tps_ff       <= 8'd0;
         enable_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_cnt_ff  <= tick_cnt_in;
         clock_ff     <= clock_in;
         alarm_ff     <= alarm_in;
         latched_ff   <= latched_in;
         valid_ff     <= valid_in;
         tps_ff       <= tps_in;
         enable_ff    <= enable_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      ok_ff       <= ok_in;
      step_cnt_ff <= step_cnt_in;
   end

   // An accepted beat blocks the input until its result is loaded.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accept");

   // While time_valid is low the time reads as zero.
   a_time_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.time_valid) |-> (rsp_data.time_bcd == 24'd0))
      else $error("time shown while not valid");

   // An alarm hit always latches the alarm state.
   a_hit_latches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.alarm_match) |-> rsp_data.in_alarm)
      else $error("alarm hit without latched alarm");

   // A failed set request always invalidates the time.
   a_fail_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.request_ok) |-> !rsp_data.time_valid)
      else $error("failed request left time valid");

endmodule

### tb/bcd_alarm_clock_checker.sv
module bcd_alarm_clock_checker
   import bca_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_beat_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_beat_type rsp_data,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [7:0]   csr_data,
   output int           mismatch_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   // Shadow copy of the clock: registers and time-keeping state.
   logic [7:0]  tps_reg;
   logic        enable_reg;
   logic [7:0]  prescale_count;
   logic [23:0] clock_now;
   logic [23:0] alarm_at;
   logic        alarm_held;
   logic        time_set;

   // Responses predicted for accepted request beats, oldest first.
   rsp_beat_type expected_rsp_q[$];

   // One BCD digit pair counts up; units roll at ten, tens at the given limit.
   function automatic logic [7:0] advance_pair(input logic [7:0] pair,
                                              input logic [2:0] tens_limit);
      int units;
      int tens;
      units = int'(pair[3:0]) + 1;
      tens  = int'(pair[7:4]);
      if (units >= int'(UNITS_WRAP)) begin
         units = 0;
         tens  = tens + 1;
         if (tens >= int'(tens_limit)) begin
            tens = 0;
         end
      end
      return {4'(tens), 4'(units)};
   endfunction

   // Hours wrap to 00 once they pass 23.
   function automatic logic [23:0] advance_hours(input logic [23:0] digits);
      digits[23:16] = advance_pair(digits[23:16], TENS_LIMIT_HR);
      if (digits[23:20] == HOUR_TENS_LAST && digits[19:16] >= HOUR_UNITS_WRAP) begin
         digits[23:16] = 8'h00;
      end
      return digits;
   endfunction

   function automatic logic [23:0] advance_minute(input logic [23:0] digits);
      digits[15:8] = advance_pair(digits[15:8], TENS_LIMIT_MS);
      if (digits[15:8] == 8'h00) begin
         digits = advance_hours(digits);
      end
      return digits;
   endfunction

   function automatic logic [23:0] advance_second(input logic [23:0] digits);
      digits[7:0] = advance_pair(digits[7:0], TENS_LIMIT_MS);
      if (digits[7:0] == 8'h00) begin
         digits = advance_minute(digits);
      end
      return digits;
   endfunction

   // Apply one request beat to the shadow state and form the response it yields.
   task automatic apply_request(input req_beat_type beat, output rsp_beat_type result);
      int term;
      int count;
      result            = '0;
      result.request_ok = 1'b1;
      case (beat.req_type)
         REQ_TICK: begin
            term  = (tps_reg == 8'd0) ? 1 : int'(tps_reg);
            count = int'(prescale_count) + 1;
            if (count >= term) begin
               count     = 0;
               clock_now = advance_second(clock_now);
            end
            prescale_count = 8'(count);
            if (enable_reg && clock_now == alarm_at) begin
               result.alarm_match = 1'b1;
               alarm_held         = 1'b1;
            end
         end
         REQ_SET_TIME, REQ_SET_ALARM: begin
            if (beat.args_present) begin
               if (beat.req_type == REQ_SET_TIME) begin
                  clock_now = beat.value_bcd;
               end else begin
                  alarm_at = beat.value_bcd;
               end
               time_set = 1'b1;
            end else begin
               // A set without digits loads nothing and marks the time invalid.
               time_set          = 1'b0;
               result.request_ok = 1'b0;
            end
         end
         REQ_SNOOZE: begin
            alarm_at = clock_now;
            repeat (beat.offset_minutes) begin
               alarm_at = advance_minute(alarm_at);
            end
            alarm_held = 1'b0;
         end
         REQ_SHUTDOWN: begin
            alarm_held = 1'b0;
         end
         default: begin
         end
      endcase
      result.time_bcd   = time_set ? clock_now : 24'h000000;
      result.alarm_bcd  = alarm_at;
      result.in_alarm   = alarm_held;
      result.time_valid = time_set;
   endtask

   task automatic compare_field(input string field, input logic [23:0] want,
                                input logic [23:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
         end
      end
   endtask

   // Watch all three channels at each edge; responses are retired before new
   // requests are predicted so a beat can never match its own prediction early.
   always @(posedge clock) begin
      rsp_beat_type due;
      if (reset) begin
         tps_reg        = 8'd0;
         enable_reg     = 1'b0;
         prescale_count = 8'd0;
         clock_now      = 24'h000000;
         alarm_at       = 24'h000000;
         alarm_held     = 1'b0;
         time_set       = 1'b0;
         mismatch_count = 0;
         expected_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TICKS_PER_SECOND: tps_reg    = csr_data;
               CSR_ALARM_ENABLE:     enable_reg = csr_data[0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: response beat %h with none outstanding",
                           $realtime, rsp_data);
               end
            end else begin
               due = expected_rsp_q.pop_front();
               compare_field("time_bcd", due.time_bcd, rsp_data.time_bcd);
               compare_field("alarm_bcd", due.alarm_bcd, rsp_data.alarm_bcd);
               compare_field("alarm_match", 24'(due.alarm_match),
                             24'(rsp_data.alarm_match));
               compare_field("in_alarm", 24'(due.in_alarm), 24'(rsp_data.in_alarm));
               compare_field("time_valid", 24'(due.time_valid),
                             24'(rsp_data.time_valid));
               compare_field("request_ok", 24'(due.request_ok),
                             24'(rsp_data.request_ok));
            end
         end
         if (req_valid && !req_stall) begin
            apply_request(req_data, due);
            expected_rsp_q.push_back(due);
         end
      end
      pending_count <= expected_rsp_q.size();
   end

endmodule

### tb/bcd_alarm_clock_tb.sv
module bcd_alarm_clock_tb;
   import bca_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         RESET_CYCLES   = 6;
   localparam int         QUIET_LIMIT    = 4000;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         TAIL_CYCLES    = 12;
   localparam int         PHASE_BEATS    = 100;
   localparam int         PHASE_COUNT    = 6;
   localparam int         DAY_SECONDS    = 86400;
   localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] REQ_LAST_UNUSED  = 3'd7;

   localparam logic [7:0] PHASE_TPS[PHASE_COUNT]    = '{8'd1, 8'd0, 8'd2, 8'd255, 8'd3, 8'd5};
   localparam bit         PHASE_ENABLE[PHASE_COUNT] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [0:0]   csr_index = CSR_TICKS_PER_SECOND;
   logic [7:0]   csr_data  = 8'd0;

   int           mismatch_count;
   int           pending_count;
   int           quiet_cycles = 0;
   int           beats_sent   = 0;
   logic [7:0]   tps_now      = 8'd0;
   bit           hold_off_req = 1'b0;

   bcd_alarm_clock i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   bcd_alarm_clock_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // End the run if no beat moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Response back-pressure: free-running stretches, short stalls, a few long
   // ones, and one very long hold-off on request to fill the block.
   initial begin
      int pick;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(1, 24)) @(posedge clock);
            end else if (pick < 92) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(15, 60)) @(posedge clock);
            end
         end
      end
   end

   function automatic int next_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Packed hh:mm:ss digits for a second of the day.
   function automatic logic [23:0] digits_of(input int secs);
      int h;
      int m;
      int s;
      h = secs / 3600;
      m = (secs / 60) % 60;
      s = secs % 60;
      return {4'(h / 10), 4'(h % 10), 4'(m / 10), 4'(m % 10), 4'(s / 10), 4'(s % 10)};
   endfunction

   // Offer one request beat, hold it until accepted, then maybe go idle.
   task automatic send_request(input logic [2:0] kind, input logic [23:0] digits,
                               input logic args, input logic [7:0] offs);
      int gap;
      req_data  <= '{req_type: kind, value_bcd: digits, args_present: args,
                     offset_minutes: offs};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      gap = next_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_tick();
      send_request(REQ_TICK, 24'($urandom()), 1'($urandom()), 8'($urandom()));
   endtask

   // Stop offering and wait until every predicted response has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Both registers are written back to back while the block is idle.
   task automatic configure(input logic [7:0] tps, input logic enable);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= CSR_TICKS_PER_SECOND;
      csr_data  <= tps;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_ALARM_ENABLE;
      csr_data  <= {7'($urandom()), enable};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tps_now = tps;
   endtask

   // Set digits: mostly legal times, sometimes raw nibbles.
   function automatic logic [23:0] random_digits();
      if ($urandom_range(0, 9) < 7) return digits_of($urandom_range(0, DAY_SECONDS - 1));
      return 24'($urandom());
   endfunction

   task automatic random_request();
      int pick;
      logic [7:0] offs;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         send_tick();
      end else if (pick < 62) begin
         send_request(REQ_SET_TIME, random_digits(), $urandom_range(0, 9) != 0,
                      8'($urandom()));
      end else if (pick < 72) begin
         send_request(REQ_SET_ALARM, random_digits(), $urandom_range(0, 9) != 0,
                      8'($urandom()));
      end else if (pick < 82) begin
         // Snooze lengths are mostly short; a few span hours.
         pick = $urandom_range(0, 99);
         if (pick < 80) offs = 8'($urandom_range(0, 10));
         else if (pick < 95) offs = 8'($urandom_range(11, 60));
         else offs = 8'($urandom_range(200, 255));
         send_request(REQ_SNOOZE, 24'($urandom()), 1'($urandom()), offs);
      end else if (pick < 92) begin
         send_request(REQ_SHUTDOWN, 24'($urandom()), 1'($urandom()), 8'($urandom()));
      end else begin
         send_request(3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED)),
                      24'($urandom()), 1'($urandom()), 8'($urandom()));
      end
   endtask

   // Set a time, put the alarm a few seconds ahead, and tick through it unless the tick cap stops short.
   task automatic alarm_scenario();
      int start;
      int lead;
      int term;
      int ticks;
      lead = $urandom_range(1, 4);
      case ($urandom_range(0, 2))
         0: start = DAY_SECONDS - 1 - $urandom_range(0, 3);
         1: start = $urandom_range(0, 23) * 3600 + 3599 - $urandom_range(0, 3);
         default: start = $urandom_range(0, DAY_SECONDS - 1);
      endcase
      term  = (tps_now == 8'd0) ? 1 : int'(tps_now);
      ticks = lead * term + $urandom_range(0, 2);
      if (ticks > 40) ticks = 40;
      send_request(REQ_SET_TIME, digits_of(start), 1'b1, 8'($urandom()));
      send_request(REQ_SET_ALARM, digits_of((start + lead) % DAY_SECONDS), 1'b1,
                   8'($urandom()));
      repeat (ticks) send_tick();
      if ($urandom_range(0, 1) != 0) begin
         send_request(REQ_SHUTDOWN, 24'($urandom()), 1'($urandom()), 8'($urandom()));
      end
   endtask

   // Directed beats: midnight wrap into an alarm, missing digits, raw nibbles,
   // hour overflow, snooze extremes, unused codes and a lowered prescaler.
   task automatic directed_beats();
      configure(8'd0, 1'b1);
      send_request(REQ_SET_TIME, 24'h235959, 1'b1, 8'h00);
      send_request(REQ_SET_ALARM, 24'h000000, 1'b1, 8'hFF);
      send_tick();
      send_tick();
      send_request(REQ_SHUTDOWN, 24'hFFFFFF, 1'b1, 8'hFF);
      send_request(REQ_SET_TIME, 24'hFFFFFF, 1'b0, 8'h00);
      send_tick();
      send_request(REQ_SNOOZE, 24'h000000, 1'b0, 8'd255);
      send_request(REQ_SET_TIME, 24'hFFFFFF, 1'b1, 8'h00);
      send_tick();
      send_request(REQ_SET_TIME, 24'h999999, 1'b1, 8'h00);
      send_tick();
      send_request(REQ_SET_TIME, 24'h245959, 1'b1, 8'h00);
      send_tick();
      send_request(REQ_SET_TIME, 24'h195959, 1'b1, 8'h00);
      send_tick();
      send_request(REQ_SET_ALARM, 24'h123456, 1'b0, 8'h00);
      send_request(REQ_SNOOZE, 24'hFFFFFF, 1'b1, 8'd0);
      send_request(REQ_FIRST_UNUSED, 24'hFFFFFF, 1'b1, 8'hFF);
      send_request(REQ_LAST_UNUSED, 24'h000000, 1'b0, 8'h00);

      // Equal time and alarm with the compare off, then the prescaler is
      // lowered below a count it has already passed.
      configure(8'd255, 1'b0);
      send_request(REQ_SET_TIME, 24'h120000, 1'b1, 8'h00);
      send_request(REQ_SET_ALARM, 24'h120000, 1'b1, 8'h00);
      repeat (5) send_tick();
      configure(8'd3, 1'b1);
      send_tick();
   endtask

   // Reset, directed beats, then random phases under different settings.
   initial begin
      int target;
      logic [7:0] tps;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      directed_beats();
      for (int p = 0; p < PHASE_COUNT; p++) begin
         tps = (p == PHASE_COUNT - 1) ? 8'($urandom_range(1, 6)) : PHASE_TPS[p];
         configure(tps, PHASE_ENABLE[p]);
         if (p == 1) hold_off_req = 1'b1;
         target = beats_sent + PHASE_BEATS;
         while (beats_sent < target) begin
            if ($urandom_range(0, 3) == 0) alarm_scenario();
            else random_request();
         end
      end
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### bcd_alarm_clock.f
hw/rtl/bca_pkg.sv
hw/rtl/bca_bump.sv
hw/rtl/bcd_alarm_clock.sv
tb/bcd_alarm_clock_checker.sv
tb/bcd_alarm_clock_tb.sv
